// ===== rtl/rmf_pkg.sv =====
// Shared constants and cell link types for the running median filter.
package rmf_pkg;

	localparam int DATA_W         = 32;
	localparam int WIN_W          = 5;
	localparam int MAX_WINDOW_DEF = 31;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);

	typedef struct packed {
		logic                     ins;
		logic                     rm;
		logic                     clr;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] e;
	} sc_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sp;
		logic                     lev;
		logic                     vld;
	} sc_fwd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     vld;
		logic                     le;
	} sc_bwd_t;

endpackage

// ===== rtl/rmf_sort_cell.sv =====
// One cell of the sorted window chain: removes the leaving value and inserts the new one.
module rmf_sort_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  rmf_pkg::sc_ctl_t ctl,
	input  rmf_pkg::sc_fwd_t lin,
	input  rmf_pkg::sc_bwd_t rin,
	output rmf_pkg::sc_fwd_t fwd,
	output rmf_pkg::sc_bwd_t bwd
);
	import rmf_pkg::*;

	logic signed [DATA_W-1:0] s_q;
	logic                     vld_q;
	logic                     lt_e;
	logic                     le_raw;
	logic                     keep;
	logic signed [DATA_W-1:0] sp;
	logic                     vp;
	logic                     lev;
	logic signed [DATA_W-1:0] nxt;

	always_comb begin
		lt_e   = s_q < ctl.e;
		le_raw = s_q <= ctl.v;
		keep   = !ctl.rm || (vld_q && lt_e);
		sp     = keep ? s_q : rin.val;
		vp     = keep ? vld_q : rin.vld;
		lev    = vp && (keep ? le_raw : rin.le);
		if (lev) begin
			nxt = sp;
		end else if (lin.lev) begin
			nxt = ctl.v;
		end else begin
			nxt = lin.sp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.ins && !ctl.rm) begin
			vld_q <= vld_q | lin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			s_q <= nxt;
		end
	end

	assign fwd.sp  = sp;
	assign fwd.lev = lev;
	assign fwd.vld = vld_q;
	assign bwd.val = s_q;
	assign bwd.vld = vld_q;
	assign bwd.le  = le_raw;

endmodule

// ===== rtl/rmf_delay_line.sv =====
// Shift line of the window's x and y values in arrival order, newest at the front.
module rmf_delay_line #(
	parameter int DEPTH = rmf_pkg::MAX_WINDOW_DEF,
	parameter int IDX_W = 5
) (
	input  logic                             clk,
	input  logic                             shift,
	input  logic signed [rmf_pkg::DATA_W-1:0] din_x,
	input  logic signed [rmf_pkg::DATA_W-1:0] din_y,
	input  logic [IDX_W-1:0]                 x_idx,
	input  logic [IDX_W-1:0]                 y_idx,
	output logic signed [rmf_pkg::DATA_W-1:0] rd_x,
	output logic signed [rmf_pkg::DATA_W-1:0] rd_y
);
	import rmf_pkg::*;

	logic signed [DATA_W-1:0] xh_q [DEPTH];
	logic signed [DATA_W-1:0] yh_q [DEPTH];

	always_ff @(posedge clk) begin
		if (shift) begin
			xh_q[0] <= din_x;
			yh_q[0] <= din_y;
			for (int i = 1; i < DEPTH; i++) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
		end
	end

	assign rd_x = xh_q[x_idx];
	assign rd_y = yh_q[y_idx];

endmodule

// ===== rtl/running_median_filter_top.sv =====
// Top level of the running median filter: control, sorted cell chain, delay line, output register.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   input    | in_valid / in_stall     | sample_x, sample_y, frame_last
//   output   | out_valid / out_stall   | out_x, out_y, run_last, frame_end
//   config   | window_size_we          | window_size_wdata
//
// A point enters the sorted chain when accepted; its result is registered from the emit state,
// so a full window takes one point per cycle unless the output stalls; the last point of a frame
// stalls the input while its result loads. A frame shorter than the window is released from the
// delay line, one result per cycle unless stalled; pass-through (even window) points skip the chain.
// Reset leaves the window empty with window_size at 5; a config write also empties it.
// A stalled output holds the register and stalls the input.
module running_median_filter_top #(
	parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              window_size_we,
	input  logic [rmf_pkg::WIN_W-1:0]         window_size_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rmf_pkg::DATA_W-1:0] sample_x,
	input  logic signed [rmf_pkg::DATA_W-1:0] sample_y,
	input  logic                              frame_last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rmf_pkg::DATA_W-1:0] out_x,
	output logic signed [rmf_pkg::DATA_W-1:0] out_y,
	output logic                              run_last,
	output logic                              frame_end
);
	import rmf_pkg::*;

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int LW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
	localparam logic [LW-1:0] MAXW_L = LW'(MAX_WINDOW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_REL  = 2'd2;

	logic [WIN_W-1:0]         w_q;
	logic [CNT_W-1:0]         fill_q;
	logic [1:0]               state_q;
	logic [1:0]               state_nxt;
	logic                     last_q;
	logic [IDX_W-1:0]         rel_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_x_q;
	logic signed [DATA_W-1:0] out_y_q;
	logic                     run_last_q;
	logic                     frame_end_q;

	logic [LW-1:0]            w_l;
	logic [LW-1:0]            fill_l;
	logic [LW-1:0]            mid_l;
	logic [LW-1:0]            wm1_l;
	logic                     pass;
	logic                     full;
	logic                     fills_up;
	logic                     out_can;
	logic                     in_ok;
	logic                     acc;
	logic                     clr;
	logic                     load_emit;
	logic                     load_rel;
	logic                     load_pass;
	logic [IDX_W-1:0]         x_idx;
	logic [IDX_W-1:0]         y_idx;
	logic signed [DATA_W-1:0] rd_x;
	logic signed [DATA_W-1:0] rd_y;
	logic signed [DATA_W-1:0] median;
	sc_ctl_t                  ctl;
	sc_fwd_t                  fwd_w [MAX_WINDOW+1];
	sc_bwd_t                  bwd_w [MAX_WINDOW+1];

	assign w_l      = LW'(w_q);
	assign fill_l   = LW'(fill_q);
	assign mid_l    = w_l >> 1;
	assign wm1_l    = w_l - LW'(1);
	assign pass     = !w_q[0] || (w_l > MAXW_L);
	assign full     = (fill_l == w_l);
	assign fills_up = ((fill_l + LW'(1)) == w_l);

	assign out_can = !out_valid_q || !out_stall;
	assign in_ok   = out_can && ((state_q == ST_IDLE) || ((state_q == ST_EMIT) && !last_q));
	assign acc     = in_valid && in_ok;

	assign load_pass = acc && pass;
	assign load_emit = (state_q == ST_EMIT) && out_can;
	assign load_rel  = (state_q == ST_REL) && out_can;

	assign clr = window_size_we || (load_emit && last_q) ||
		(load_rel && (rel_q == IDX_W'(0)));

	assign x_idx = (state_q == ST_REL) ? rel_q : mid_l[IDX_W-1:0];
	assign y_idx = (state_q == ST_REL) ? rel_q : wm1_l[IDX_W-1:0];

	assign ctl.ins = acc && !pass;
	assign ctl.rm  = full;
	assign ctl.clr = clr;
	assign ctl.v   = sample_y;
	assign ctl.e   = rd_y;

	assign fwd_w[0].sp           = '0;
	assign fwd_w[0].lev          = 1'b1;
	assign fwd_w[0].vld          = 1'b1;
	assign bwd_w[MAX_WINDOW].val = '0;
	assign bwd_w[MAX_WINDOW].vld = 1'b0;
	assign bwd_w[MAX_WINDOW].le  = 1'b0;

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		rmf_sort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.lin    (fwd_w[g]),
			.rin    (bwd_w[g+1]),
			.fwd    (fwd_w[g+1]),
			.bwd    (bwd_w[g])
		);
	end

	assign median = bwd_w[mid_l[IDX_W-1:0]].val;

	rmf_delay_line #(
		.DEPTH (MAX_WINDOW),
		.IDX_W (IDX_W)
	) u_delay (
		.clk   (clk),
		.shift (ctl.ins),
		.din_x (sample_x),
		.din_y (sample_y),
		.x_idx (x_idx),
		.y_idx (y_idx),
		.rd_x  (rd_x),
		.rd_y  (rd_y)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q) inside
			ST_IDLE, ST_EMIT: begin
				if (state_q == ST_EMIT && out_can) begin
					state_nxt = ST_IDLE;
				end
				if (acc && !pass) begin
					if (full || fills_up) begin
						state_nxt = ST_EMIT;
					end else if (frame_last) begin
						state_nxt = ST_REL;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_REL: begin
				if (load_rel && (rel_q == IDX_W'(0))) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= WIN_RESET;
			fill_q      <= '0;
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			rel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (window_size_we) begin
				w_q <= window_size_wdata;
			end
			if (clr) begin
				fill_q <= '0;
			end else if (ctl.ins && !full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (acc) begin
				last_q <= frame_last;
			end
			if (acc && !pass && !full && !fills_up) begin
				rel_q <= fill_q[IDX_W-1:0];
			end else if (load_rel) begin
				rel_q <= rel_q - IDX_W'(1);
			end
			if (load_pass || load_emit || load_rel) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pass) begin
			out_x_q     <= sample_x;
			out_y_q     <= sample_y;
			run_last_q  <= 1'b1;
			frame_end_q <= frame_last;
		end else if (load_emit) begin
			out_x_q     <= rd_x;
			out_y_q     <= median;
			run_last_q  <= 1'b1;
			frame_end_q <= last_q;
		end else if (load_rel) begin
			out_x_q     <= rd_x;
			out_y_q     <= rd_y;
			run_last_q  <= (rel_q == IDX_W'(0));
			frame_end_q <= (rel_q == IDX_W'(0));
		end
	end

	assign in_stall  = !in_ok;
	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

// ===== test/tb_running_median_filter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the running median filter: directed table, then random frames.
module tb_running_median_filter_top;

	import rmf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_WIN        = MAX_WINDOW_DEF;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic                     run_last;
		logic                     frame_end;
	} median_point_t;

	typedef enum bit {ROW_POINT, ROW_WINDOW} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [WIN_W-1:0]         win;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic                     last;
		bit                       typed;
		logic signed [DATA_W-1:0] ex;
		logic signed [DATA_W-1:0] ey;
	} stim_row_t;

	logic                     clk               = 1'b0;
	logic                     arst_n            = 1'b0;
	logic                     window_size_we    = 1'b0;
	logic [WIN_W-1:0]         window_size_wdata = '0;
	logic                     in_valid          = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample_x          = '0;
	logic signed [DATA_W-1:0] sample_y          = '0;
	logic                     frame_last        = 1'b0;
	logic                     out_valid;
	logic                     out_stall         = 1'b0;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic                     run_last;
	logic                     frame_end;

	bit quiet = 1'b0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	median_point_t pending_points[$];
	stim_row_t     directed_rows[$];

	logic [WIN_W-1:0]         win_len = WIN_RESET;
	logic signed [DATA_W-1:0] x_line[MAX_WIN];
	logic signed [DATA_W-1:0] y_line[MAX_WIN];
	logic signed [DATA_W-1:0] ordered_y[MAX_WIN];
	int unsigned              held = 0;
	int unsigned              slot = 0;

	running_median_filter_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_size_we    (window_size_we),
		.window_size_wdata (window_size_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample_x          (sample_x),
		.sample_y          (sample_y),
		.frame_last        (frame_last),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_x             (out_x),
		.out_y             (out_y),
		.run_last          (run_last),
		.frame_end         (frame_end)
	);

	always #10 clk = ~clk;

	function automatic void add_expected(input median_point_t p);
		pending_points = {pending_points, p};
	endfunction

	function automatic void insert_ordered(input logic signed [DATA_W-1:0] v,
			input int unsigned count);
		int unsigned pos;
		pos = count;
		while (pos > 0 && v < ordered_y[pos-1]) begin
			ordered_y[pos] = ordered_y[pos-1];
			pos--;
		end
		ordered_y[pos] = v;
	endfunction

	function automatic void remove_ordered(input logic signed [DATA_W-1:0] v,
			input int unsigned count);
		int unsigned i;
		i = 0;
		while (i < count && ordered_y[i] != v)
			i++;
		if (i >= count)
			return;
		for (; i + 1 < count; i++)
			ordered_y[i] = ordered_y[i+1];
	endfunction

	function automatic void median_step(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] y, input logic last);
		int unsigned w, center, k;
		w = win_len;
		if (!win_len[0]) begin
			add_expected('{x, y, 1'b1, last});
			if (last) begin
				held = 0;
				slot = 0;
			end
			return;
		end
		if (slot >= w || held > w) begin
			held = 0;
			slot = 0;
		end
		if (held < w) begin
			x_line[slot] = x;
			y_line[slot] = y;
			insert_ordered(y, held);
			held++;
			slot = (slot + 1 == w) ? 0 : slot + 1;
			if (held < w) begin
				// A frame shorter than the window leaves in arrival order at its last point.
				if (last) begin
					for (k = 0; k < held; k++)
						add_expected('{x_line[k], y_line[k],
							k + 1 == held, k + 1 == held});
					held = 0;
					slot = 0;
				end
				return;
			end
		end else begin
			remove_ordered(y_line[slot], w);
			insert_ordered(y, w - 1);
			x_line[slot] = x;
			y_line[slot] = y;
			slot = (slot + 1 == w) ? 0 : slot + 1;
		end
		center = (slot + w / 2) % w;
		add_expected('{x_line[center], ordered_y[w/2], 1'b1, last});
		if (last) begin
			held = 0;
			slot = 0;
		end
	endfunction

	function automatic void plan(input row_kind_t kind, input logic [WIN_W-1:0] win,
			input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
			input logic last, input bit typed, input logic signed [DATA_W-1:0] ex,
			input logic signed [DATA_W-1:0] ey);
		stim_row_t r;
		r = '{kind, win, x, y, last, typed, ex, ey};
		directed_rows = {directed_rows, r};
	endfunction

	task automatic send_point(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] y, input logic last, input bit typed,
			input median_point_t typed_point);
		while (!quiet && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		sample_x   <= x;
		sample_y   <= y;
		frame_last <= last;
		do
			@(posedge clk);
		while (in_stall);
		median_step(x, y, last);
		if (typed)
			pending_points[pending_points.size()-1] = typed_point;
	endtask

	// The block must be idle before the register changes, so the sender drains first.
	task automatic set_window(input logic [WIN_W-1:0] w);
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		window_size_we    <= 1'b1;
		window_size_wdata <= w;
		@(posedge clk);
		window_size_we <= 1'b0;
		win_len = w;
		held    = 0;
		slot    = 0;
	endtask

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(0, 99) < 30);

	always @(posedge clk) begin
		median_point_t want;
		if (out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, got x=%h y=%h", $time, out_x, out_y);
			end else begin
				want = pending_points.pop_front();
				if (out_x !== want.x) begin
					mismatch_count++;
					$display("%0t: out_x expected %h, got %h", $time, want.x, out_x);
				end
				if (out_y !== want.y) begin
					mismatch_count++;
					$display("%0t: out_y expected %h, got %h", $time, want.y, out_y);
				end
				if (run_last !== want.run_last) begin
					mismatch_count++;
					$display("%0t: run_last expected %b, got %b", $time, want.run_last,
						run_last);
				end
				if (frame_end !== want.frame_end) begin
					mismatch_count++;
					$display("%0t: frame_end expected %b, got %b", $time, want.frame_end,
						frame_end);
				end
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		stim_row_t                row;
		median_point_t            typed_point;
		logic signed [DATA_W-1:0] ry;
		logic [WIN_W-1:0]         w;
		int unsigned              sent, len, k;
		bit                       broken;

		// Short frame at the reset window of five.
		plan(ROW_POINT, 0, 32'sd1, 32'sd10, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd2, -32'sd5, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd3, 32'sd7, 1'b1, 0, 0, 0);
		// Zero window passes points through unchanged.
		plan(ROW_WINDOW, 0, 0, 0, 0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1, 32'h80000000, 32'h7FFFFFFF);
		plan(ROW_POINT, 0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1, 32'h7FFFFFFF, 32'h80000000);
		// Window of one gives every point back at once.
		plan(ROW_WINDOW, 1, 0, 0, 0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd5, 32'sd6, 1'b0, 1, 32'sd5, 32'sd6);
		plan(ROW_POINT, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF);
		// Window of three with extreme and repeated y values.
		plan(ROW_WINDOW, 3, 0, 0, 0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd10, 32'h7FFFFFFF, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd11, 32'h80000000, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd12, 32'sd0, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd13, 32'sd0, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd14, 32'sd0, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd15, 32'h80000000, 1'b1, 0, 0, 0);
		// Largest window with a short frame.
		plan(ROW_WINDOW, 31, 0, 0, 0, 0, 0, 0);
		plan(ROW_POINT, 0, -32'sd1, 32'sd4, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, -32'sd2, 32'sd3, 1'b1, 0, 0, 0);
		// A register write in mid-frame drops the points held so far.
		plan(ROW_WINDOW, 3, 0, 0, 0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd20, 32'sd9, 1'b0, 0, 0, 0);
		plan(ROW_POINT, 0, 32'sd21, 32'sd8, 1'b0, 0, 0, 0);
		plan(ROW_WINDOW, 5, 0, 0, 0, 0, 0, 0);
		for (k = 0; k < 5; k++)
			plan(ROW_POINT, 0, 32'(30 + k), 32'(k * 3 % 5), k == 4, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WINDOW)
				set_window(row.win);
			else begin
				typed_point = '{row.ex, row.ey, 1'b1, row.last};
				send_point(row.x, row.y, row.last, row.typed, typed_point);
			end
		end

		sent   = 0;
		broken = 1'b1;
		w      = win_len;
		while (sent < 345) begin
			quiet = (sent >= 120 && sent < 200);
			if (broken || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9)) inside
					[0:5]:   w = WIN_W'(2 * $urandom_range(0, 4) + 1);
					[6:7]:   w = WIN_W'($urandom_range(0, 31));
					8:       w = WIN_W'(2 * $urandom_range(0, 15));
					default: w = WIN_W'(MAX_WIN);
				endcase
				set_window(w);
			end
			if (!w[0])
				len = $urandom_range(1, 12);
			else if ($urandom_range(0, 4) == 0)
				len = $urandom_range(1, w);
			else
				len = $urandom_range(w, w + 12);
			broken = ($urandom_range(0, 9) == 0);
			for (k = 0; k < len; k++) begin
				case ($urandom_range(0, 3))
					0:       ry = DATA_W'($urandom_range(0, 6)) - 32'sd3;
					default: ry = $urandom;
				endcase
				send_point($urandom, ry, k + 1 == len && !broken, 0, '0);
			end
			sent += len;
		end

		in_valid <= 1'b0;
		quiet = 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
